// File: rtl/hic_pkg.sv
`timescale 1ns / 1ps

package hic_pkg;

  typedef enum logic [1:0] {
    KIND_NULL,
    KIND_COOL,
    KIND_POLY
  } kind_t;

  // what travels beside the arithmetic through every stage up to output select
  typedef struct packed {
    kind_t              kind;
    logic signed [11:0] temp;
  } meta_t;

  localparam logic signed [11:0] THRESHOLD = 12'sd750;

  // regression coefficients scaled by 1e8, premultiplied by their decimal weight
  localparam logic signed [49:0] K1_E4 = -50'sd42379000000000;
  localparam logic signed [38:0] K2_E3 = 39'sd204901523000;
  localparam logic signed [40:0] K3_E3 = 41'sd1014333127000;
  localparam logic signed [32:0] K4_E2 = -33'sd2247554100;
  localparam logic signed [27:0] K5_E2 = -28'sd68378300;
  localparam logic signed [30:0] K6_E2 = -31'sd548171700;
  localparam logic signed [21:0] K7_E1 = 22'sd1228740;
  localparam logic signed [20:0] K8_E1 = 21'sd852820;
  localparam logic signed [8:0]  K9    = -9'sd199;

  localparam logic signed [56:0] LIMIT = 57'sd300000000000000;
  localparam logic signed [56:0] HALF  = 57'sd50000000000;
  localparam logic [36:0]        TENTH = 37'd100000000000;
  // floor(2^60 / 1e11): quotient estimate from bits above 20, shifted by 40
  localparam logic [23:0]        RECIP = 24'd11529215;

endpackage

// File: rtl/heat_index_calc_core.sv
`timescale 1ns / 1ps

// heat index from a temperature and relative humidity sample pair
//
// sample channel: temp_tenths (tenths of deg F, signed), humidity_tenths
// (tenths of a percent) and a presence flag for each, moved on a
// sample_valid / sample_ready beat
// result channel: index_tenths, index_ok and used_formula, moved on a
// result_valid / result_ready beat; one result beat per sample beat, in order
//
// a new sample can be taken every cycle while sample_ready is high. the
// nine stages are: squares, constant products, coefficient sums, humidity
// products, final sum, magnitude and range check, reciprocal estimate,
// back-multiply, correction and output select
//
// each stage holds its own valid bit and ready is chained backward, so a
// stalled receiver only holds the stages that carry data; empty stages keep
// filling and sample_ready drops once the whole pipe is full
//
// reset empties the pipe; nothing is in flight and result_valid is low after it
module heat_index_calc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  logic signed [11:0]  temp_tenths,
  input  logic                temp_ok,
  input  logic [9:0]          humidity_tenths,
  input  logic                humidity_ok,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [12:0]  index_tenths,
  output logic                index_ok,
  output logic                used_formula
);

  logic               poly_valid;
  logic               poly_ready;
  logic signed [56:0] poly_n;
  hic_pkg::meta_t     poly_meta;

  hic_poly u_poly (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_ready    (sample_ready),
    .temp_tenths     (temp_tenths),
    .temp_ok         (temp_ok),
    .humidity_tenths (humidity_tenths),
    .humidity_ok     (humidity_ok),
    .poly_valid      (poly_valid),
    .poly_ready      (poly_ready),
    .poly_n          (poly_n),
    .poly_meta       (poly_meta)
  );

  hic_round u_round (
    .clk          (clk),
    .rst          (rst),
    .poly_valid   (poly_valid),
    .poly_ready   (poly_ready),
    .poly_n       (poly_n),
    .poly_meta    (poly_meta),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .index_tenths (index_tenths),
    .index_ok     (index_ok),
    .used_formula (used_formula)
  );

  // invalid results carry zero
  a_null_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && !index_ok |-> index_tenths == 13'sd0)
    else $error("invalid result with nonzero index");

  // formula results stay inside the range limit
  a_formula_range : assert property (@(posedge clk) disable iff (rst)
    result_valid && used_formula && index_ok |->
      (index_tenths >= -13'sd3000) && (index_tenths <= 13'sd3000))
    else $error("formula result outside range");

  // pass-through only happens below the threshold
  a_cool_below : assert property (@(posedge clk) disable iff (rst)
    result_valid && index_ok && !used_formula |-> index_tenths < 13'sd750)
    else $error("pass-through at or above threshold");

  // pipe is empty right after reset
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

// File: rtl/hic_poly.sv
`timescale 1ns / 1ps

module hic_poly (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  logic signed [11:0]  temp_tenths,
  input  logic                temp_ok,
  input  logic [9:0]          humidity_tenths,
  input  logic                humidity_ok,
  output logic                poly_valid,
  input  logic                poly_ready,
  output logic signed [56:0]  poly_n,
  output hic_pkg::meta_t      poly_meta
);

  logic [5:1] v;
  logic [6:1] rdy;
  logic [5:1] v_in;

  hic_pkg::meta_t meta_in;
  hic_pkg::meta_t meta1, meta2, meta3, meta4, meta5;

  logic [10:0] t1;
  logic [9:0]  h1, h2, h3;
  logic [21:0] tt1;
  logic [19:0] hh1, hh2, hh3;

  logic signed [49:0] c2t, c5tt;
  logic signed [43:0] c4t, c7tt;
  logic signed [31:0] c8t;
  logic signed [30:0] c9tt;

  logic signed [49:0] a0, a0_4;
  logic signed [44:0] a1;
  logic signed [32:0] a2;

  logic signed [54:0] p1;
  logic signed [52:0] p2;
  logic signed [56:0] n5;

  assign rdy[6] = poly_ready;
  assign v_in   = {v[4:1], sample_valid};

  genvar k;
  generate
    for (k = 1; k <= 5; k++) begin : g_rdy
      assign rdy[k] = ~v[k] | rdy[k+1];
    end
  endgenerate

  assign sample_ready = rdy[1];

  always_comb begin
    meta_in.temp = temp_tenths;
    if (!temp_ok || !humidity_ok) begin
      meta_in.kind = hic_pkg::KIND_NULL;
    end else if (temp_tenths < hic_pkg::THRESHOLD) begin
      meta_in.kind = hic_pkg::KIND_COOL;
    end else begin
      meta_in.kind = hic_pkg::KIND_POLY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 1; i <= 5; i++) begin
        if (rdy[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  // squares; on the formula path the temperature is positive and below 2048
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      meta1 <= meta_in;
      t1    <= temp_tenths[10:0];
      h1    <= humidity_tenths;
      tt1   <= temp_tenths[10:0] * temp_tenths[10:0];
      hh1   <= humidity_tenths * humidity_tenths;
    end
  end

  // constant products of t and t^2 for the three humidity coefficients
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      meta2 <= meta1;
      h2    <= h1;
      hh2   <= hh1;
      c2t   <= hic_pkg::K2_E3 * $signed({1'b0, t1});
      c5tt  <= hic_pkg::K5_E2 * $signed({1'b0, tt1});
      c4t   <= hic_pkg::K4_E2 * $signed({1'b0, t1});
      c7tt  <= hic_pkg::K7_E1 * $signed({1'b0, tt1});
      c8t   <= hic_pkg::K8_E1 * $signed({1'b0, t1});
      c9tt  <= hic_pkg::K9 * $signed({1'b0, tt1});
    end
  end

  // n = a0 + a1*h + a2*h^2
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      meta3 <= meta2;
      h3    <= h2;
      hh3   <= hh2;
      a0    <= hic_pkg::K1_E4 + c2t + c5tt;
      a1    <= 45'(hic_pkg::K3_E3) + 45'(c4t) + 45'(c7tt);
      a2    <= 33'(hic_pkg::K6_E2) + 33'(c8t) + 33'(c9tt);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      meta4 <= meta3;
      a0_4  <= a0;
      p1    <= a1 * $signed({1'b0, h3});
      p2    <= a2 * $signed({1'b0, hh3});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      meta5 <= meta4;
      n5    <= 57'(a0_4) + 57'(p1) + 57'(p2);
    end
  end

  assign poly_valid = v[5];
  assign poly_n     = n5;
  assign poly_meta  = meta5;

endmodule

// File: rtl/hic_round.sv
`timescale 1ns / 1ps

module hic_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                poly_valid,
  output logic                poly_ready,
  input  logic signed [56:0]  poly_n,
  input  hic_pkg::meta_t      poly_meta,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [12:0]  index_tenths,
  output logic                index_ok,
  output logic                used_formula
);

  logic [4:1] v;
  logic [5:1] rdy;
  logic [4:1] v_in;

  hic_pkg::meta_t meta6, meta7, meta8;
  logic neg6, neg7, neg8;
  logic bad6, bad7, bad8;
  logic [48:0] x6, x7, x8;
  logic [12:0] qe7, qe8;
  logic [49:0] qp8;

  logic [52:0] recip_prod;
  logic [50:0] next_bound;
  logic        step;
  logic [12:0] q;
  logic signed [12:0] index_next;
  logic        ok_next;
  logic        formula_next;

  assign rdy[5] = result_ready;
  assign v_in   = {v[3:1], poly_valid};

  genvar k;
  generate
    for (k = 1; k <= 4; k++) begin : g_rdy
      assign rdy[k] = ~v[k] | rdy[k+1];
    end
  endgenerate

  assign poly_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 1; i <= 4; i++) begin
        if (rdy[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  // magnitude plus half a tenth; only meaningful when in range
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      meta6 <= poly_meta;
      neg6  <= poly_n[56];
      bad6  <= (poly_n < -hic_pkg::LIMIT) || (poly_n > hic_pkg::LIMIT);
      x6    <= 49'(poly_n[56] ? hic_pkg::HALF - poly_n : poly_n + hic_pkg::HALF);
    end
  end

  // reciprocal estimate, never above the true quotient and at most one below
  assign recip_prod = x6[48:20] * hic_pkg::RECIP;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      meta7 <= meta6;
      neg7  <= neg6;
      bad7  <= bad6;
      x7    <= x6;
      qe7   <= recip_prod[52:40];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      meta8 <= meta7;
      neg8  <= neg7;
      bad8  <= bad7;
      x8    <= x7;
      qe8   <= qe7;
      qp8   <= qe7 * hic_pkg::TENTH;
    end
  end

  always_comb begin
    next_bound   = 51'(qp8) + 51'(hic_pkg::TENTH);
    step         = {2'b00, x8} >= next_bound;
    q            = qe8 + 13'(step);
    index_next   = '0;
    ok_next      = 1'b0;
    formula_next = 1'b0;
    case (meta8.kind)
      hic_pkg::KIND_COOL: begin
        index_next = {meta8.temp[11], meta8.temp};
        ok_next    = 1'b1;
      end
      hic_pkg::KIND_POLY: begin
        formula_next = 1'b1;
        if (!bad8) begin
          index_next = neg8 ? -$signed(q) : $signed(q);
          ok_next    = 1'b1;
        end
      end
      default: begin
        index_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      index_tenths <= index_next;
      index_ok     <= ok_next;
      used_formula <= formula_next;
    end
  end

  assign result_valid = v[4];

endmodule
